FILE: sv/pbtt_pkg.sv
// Shared types and constants of the paged block translation table.
`timescale 1ns / 1ps
package pbtt_pkg;

  // Command codes
  localparam logic [2:0] CMD_MAP    = 3'd0;
  localparam logic [2:0] CMD_UNMAP  = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_SET_WR = 3'd3;
  localparam logic [2:0] CMD_FORK   = 3'd4;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 1;
  localparam logic [0:0] CFG_START_OWNER = 1'd0;
  localparam logic [0:0] CFG_CACHE_KIND  = 1'd1;

  // Fixed field widths
  localparam int IDX_W   = 10;
  localparam int OWNER_W = 16;
  localparam int PHYS_W  = 16;
  localparam int COUNT_W = 11;
  localparam int KIND_W  = 2;

  // Decoded request, as queued between front and back
  typedef struct packed {
    logic [2:0]         cmd;
    logic               addressed;  // map, unmap, lookup, set writable
    logic               in_range;   // index below table size
    logic [IDX_W-1:0]   idx;
    logic [OWNER_W-1:0] owner;
    logic [PHYS_W-1:0]  phys;
    logic               wr;
    logic [OWNER_W-1:0] child;
  } pbtt_req_t;

  // Queue head offered to the back end
  typedef struct packed {
    logic      avail;
    pbtt_req_t req;
  } pbtt_head_t;

  // Back end control toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } pbtt_ctl_t;

endpackage

FILE: sv/pbtt_front.sv
// Front end: accepts commands, decodes them and queues them for the back end.
`timescale 1ns / 1ps
module pbtt_front #(
  parameter int LOGICAL_BLOCKS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_cmd,
  input  logic [pbtt_pkg::IDX_W-1:0]    in_logical_index,
  input  logic [pbtt_pkg::OWNER_W-1:0]  in_entry_owner,
  input  logic [pbtt_pkg::PHYS_W-1:0]   in_physical_block,
  input  logic                          in_writable_in,
  input  logic [pbtt_pkg::OWNER_W-1:0]  in_child_owner,
  input  pbtt_pkg::pbtt_ctl_t           ctl,
  output pbtt_pkg::pbtt_head_t          head
);
  import pbtt_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  pbtt_req_t  q_r [QUEUE_DEPTH];
  logic [0:0] wr_ptr_r, wr_ptr_nxt;
  logic [0:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       accept;
  logic       pop;
  pbtt_req_t  req_in;

  // Decode and classify the incoming request
  always_comb begin
    req_in.cmd       = in_cmd;
    req_in.addressed = (in_cmd == CMD_MAP) || (in_cmd == CMD_UNMAP) ||
                       (in_cmd == CMD_LOOKUP) || (in_cmd == CMD_SET_WR);
    req_in.in_range  = int'(in_logical_index) < LOGICAL_BLOCKS;
    req_in.idx       = in_logical_index;
    req_in.owner     = in_entry_owner;
    req_in.phys      = in_physical_block;
    req_in.wr        = in_writable_in;
    req_in.child     = in_child_owner;
  end

  // Hold off while the queue is full or the table is being cleared
  assign busy   = ctl.clearing || (q_cnt_r == 2'(QUEUE_DEPTH));
  assign accept = start && !busy;
  assign pop    = ctl.pop && (q_cnt_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r + 2'(accept) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= req_in;
    end
  end

  assign head.avail = (q_cnt_r != 2'd0);
  assign head.req   = q_r[rd_ptr_r];

endmodule

FILE: sv/pbtt_back.sv
// Back end: table memory, read-modify-write of entries, fork walk and reset clear.
`timescale 1ns / 1ps
module pbtt_back #(
  parameter int LOGICAL_BLOCKS   = 1024,
  parameter int PHYSICAL_ID_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbtt_pkg::pbtt_head_t          head,
  output pbtt_pkg::pbtt_ctl_t           ctl,
  input  logic [pbtt_pkg::OWNER_W-1:0]  start_owner,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [pbtt_pkg::PHYS_W-1:0]   out_physical_block_out,
  output logic                          out_writable_out,
  output logic [pbtt_pkg::OWNER_W-1:0]  out_entry_owner_out,
  output logic [pbtt_pkg::COUNT_W-1:0]  out_entry_count,
  output logic [pbtt_pkg::OWNER_W-1:0]  out_table_owner
);
  import pbtt_pkg::*;

  localparam int AW = $clog2(LOGICAL_BLOCKS);
  localparam int CW = $clog2(LOGICAL_BLOCKS + 1);
  localparam int PW = PHYSICAL_ID_BITS;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_FORK  = 2'd3;

  typedef struct packed {
    logic               valid;
    logic               wr;
    logic [OWNER_W-1:0] owner;
    logic [PW-1:0]      phys;
  } word_t;

  word_t mem [LOGICAL_BLOCKS];
  word_t mem_rd_q;
  logic  mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  word_t mem_wd;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      walk_r, walk_nxt;
  logic [AW-1:0]      fork_wa_r, fork_wa_nxt;
  pbtt_req_t          cur_r, cur_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic               forked_r, forked_nxt;
  logic               hit;

  logic               ov_r, ov_nxt;
  logic               of_r, of_nxt;
  logic [PHYS_W-1:0]  op_r, op_nxt;
  logic               ow_r, ow_nxt;
  logic [OWNER_W-1:0] oo_r, oo_nxt;
  logic [COUNT_W-1:0] oc_r, oc_nxt;
  logic [OWNER_W-1:0] ot_r, ot_nxt;

  // Sequencer: clear pass, request read, entry update, fork walk
  always_comb begin
    state_nxt   = state_r;
    walk_nxt    = walk_r;
    fork_wa_nxt = fork_wa_r;
    cur_nxt     = cur_r;
    count_nxt   = count_r;
    owner_nxt   = owner_r;
    forked_nxt  = forked_r;
    ov_nxt      = 1'b0;
    of_nxt      = of_r;
    op_nxt      = op_r;
    ow_nxt      = ow_r;
    oo_nxt      = oo_r;
    oc_nxt      = oc_r;
    ot_nxt      = ot_r;
    mem_we      = 1'b0;
    mem_wa      = walk_r[AW-1:0];
    mem_wd      = '0;
    mem_ra      = AW'(head.req.idx);
    ctl.pop     = 1'b0;
    ctl.clearing = (state_r == S_CLEAR);
    hit         = cur_r.addressed && cur_r.in_range && mem_rd_q.valid;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = walk_r[AW-1:0];
        mem_wd = '0;
        if (walk_r == CW'(LOGICAL_BLOCKS - 1)) begin
          walk_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          walk_nxt = walk_r + CW'(1);
        end
      end
      S_IDLE: begin
        // read of the addressed entry is issued this cycle
        if (head.avail) begin
          ctl.pop = 1'b1;
          cur_nxt = head.req;
          if (head.req.cmd == CMD_FORK) begin
            walk_nxt  = '0;
            state_nxt = S_FORK;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        mem_wa = AW'(cur_r.idx);
        mem_wd = mem_rd_q;
        if (cur_r.cmd == CMD_MAP && cur_r.in_range) begin
          mem_we       = 1'b1;
          mem_wd.valid = 1'b1;
          mem_wd.wr    = cur_r.wr;
          mem_wd.owner = cur_r.owner;
          mem_wd.phys  = PW'(cur_r.phys);
          if (!hit) begin
            count_nxt = count_r + CW'(1);
          end
        end else if (cur_r.cmd == CMD_UNMAP && hit) begin
          mem_we       = 1'b1;
          mem_wd.valid = 1'b0;
          mem_wd.wr    = 1'b0;
          count_nxt    = count_r - CW'(1);
        end else if (cur_r.cmd == CMD_SET_WR && hit) begin
          mem_we    = 1'b1;
          mem_wd.wr = cur_r.wr;
        end
        ov_nxt    = 1'b1;
        of_nxt    = hit;
        op_nxt    = hit ? PHYS_W'(mem_rd_q.phys) : '0;
        ow_nxt    = hit && mem_rd_q.wr;
        oo_nxt    = hit ? mem_rd_q.owner : '0;
        oc_nxt    = COUNT_W'(count_nxt);
        ot_nxt    = forked_r ? owner_r : start_owner;
        state_nxt = S_IDLE;
      end
      S_FORK: begin
        // read entry k while writing back entry k-1
        mem_ra      = walk_r[AW-1:0];
        fork_wa_nxt = walk_r[AW-1:0];
        mem_wa      = fork_wa_r;
        mem_wd      = mem_rd_q;
        mem_wd.wr   = 1'b0;
        mem_wd.owner = cur_r.child;
        mem_we      = (walk_r != '0) && mem_rd_q.valid;
        if (walk_r == CW'(LOGICAL_BLOCKS)) begin
          owner_nxt  = cur_r.child;
          forked_nxt = 1'b1;
          ov_nxt     = 1'b1;
          of_nxt     = 1'b0;
          op_nxt     = '0;
          ow_nxt     = 1'b0;
          oo_nxt     = '0;
          oc_nxt     = COUNT_W'(count_r);
          ot_nxt     = cur_r.child;
          walk_nxt   = '0;
          state_nxt  = S_IDLE;
        end else begin
          walk_nxt = walk_r + CW'(1);
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      walk_r    <= '0;
      count_r   <= '0;
      owner_r   <= '0;
      forked_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      walk_r    <= walk_nxt;
      count_r   <= count_nxt;
      owner_r   <= owner_nxt;
      forked_r  <= forked_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fork_wa_r <= fork_wa_nxt;
    cur_r     <= cur_nxt;
    of_r      <= of_nxt;
    op_r      <= op_nxt;
    ow_r      <= ow_nxt;
    oo_r      <= oo_nxt;
    oc_r      <= oc_nxt;
    ot_r      <= ot_nxt;
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  assign out_valid              = ov_r;
  assign out_found              = of_r;
  assign out_physical_block_out = op_r;
  assign out_writable_out       = ow_r;
  assign out_entry_owner_out    = oo_r;
  assign out_entry_count        = oc_r;
  assign out_table_owner        = ot_r;

endmodule

FILE: sv/paged_block_translation_table.sv
// Top level of the paged block translation table.
//
// A per-sequence page table mapping logical block indices to physical ids,
// a writable flag and an owner id. Commands (map, unmap, lookup, set
// writable, fork) are taken at a clock edge with start high and busy low.
// Each command gives one result on the out_ ports for one cycle, marked by
// out_valid; the receiver cannot stall, so results are never held.
// A command is queued, then popped while its entry read is issued; the
// entry is then updated as the command asks and the result registered.
// The back end finishes one command before it pops the next, held to the
// read-then-write of the single table memory port pair. A two-entry
// request queue lets commands arrive while the back end works; busy rises
// when it is full. Fork walks every entry, with the queue absorbing at
// most two further commands meanwhile. After reset a clearing pass zeroes
// the table; busy stays high during it. Configuration writes (cfg_we,
// cfg_index, cfg_wdata) take effect at once and are accepted at any time,
// but are meant to be issued only while no command is outstanding.
`timescale 1ns / 1ps
module paged_block_translation_table #(
  parameter int LOGICAL_BLOCKS   = 1024,
  parameter int PHYSICAL_ID_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         in_cmd,
  input  logic [pbtt_pkg::IDX_W-1:0]         in_logical_index,
  input  logic [pbtt_pkg::OWNER_W-1:0]       in_entry_owner,
  input  logic [pbtt_pkg::PHYS_W-1:0]        in_physical_block,
  input  logic                               in_writable_in,
  input  logic [pbtt_pkg::OWNER_W-1:0]       in_child_owner,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [pbtt_pkg::PHYS_W-1:0]        out_physical_block_out,
  output logic                               out_writable_out,
  output logic [pbtt_pkg::OWNER_W-1:0]       out_entry_owner_out,
  output logic [pbtt_pkg::COUNT_W-1:0]       out_entry_count,
  output logic [pbtt_pkg::OWNER_W-1:0]       out_table_owner,
  input  logic                               cfg_we,
  input  logic [pbtt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbtt_pkg::OWNER_W-1:0]       cfg_wdata
);
  import pbtt_pkg::*;

  pbtt_head_t         head;
  pbtt_ctl_t          ctl;
  logic [OWNER_W-1:0] start_owner_r;
  logic [KIND_W-1:0]  cache_kind_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_owner_r <= '0;
      cache_kind_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_OWNER: start_owner_r <= cfg_wdata;
        CFG_CACHE_KIND:  cache_kind_r  <= cfg_wdata[KIND_W-1:0];
      endcase
    end
  end

  pbtt_front #(
    .LOGICAL_BLOCKS (LOGICAL_BLOCKS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_logical_index  (in_logical_index),
    .in_entry_owner    (in_entry_owner),
    .in_physical_block (in_physical_block),
    .in_writable_in    (in_writable_in),
    .in_child_owner    (in_child_owner),
    .ctl               (ctl),
    .head              (head)
  );

  pbtt_back #(
    .LOGICAL_BLOCKS   (LOGICAL_BLOCKS),
    .PHYSICAL_ID_BITS (PHYSICAL_ID_BITS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .head                   (head),
    .ctl                    (ctl),
    .start_owner            (start_owner_r),
    .out_valid              (out_valid),
    .out_found              (out_found),
    .out_physical_block_out (out_physical_block_out),
    .out_writable_out       (out_writable_out),
    .out_entry_owner_out    (out_entry_owner_out),
    .out_entry_count        (out_entry_count),
    .out_table_owner        (out_table_owner)
  );

`ifndef SYNTHESIS
  // Reset starts the clearing pass: no requests are taken right after it
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // No result is produced in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // The back end returns to idle after every result, so results never come back to back
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  // A miss reports an empty entry
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_physical_block_out == '0 && !out_writable_out &&
       out_entry_owner_out == '0))
    else $error("entry fields set on a miss");
`endif

endmodule
